// ===== design/dpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared widths, register indexes, types and saturation helpers for the
// depth pixel deprojection pipeline.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int PIX_BITS   = 12;
    localparam int DEPTH_BITS = 16;
    localparam int CFG_AW     = 5;

    localparam int DX_W   = ((PIX_BITS + 4 > 16) ? PIX_BITS + 4 : 16) + 1;
    localparam int CO_W   = 24;
    localparam int SQ_W   = 28;
    localparam int R2_W   = 29;
    localparam int T_W    = 30;
    localparam int SUM_W  = 38;
    localparam int WIDE_W = 48;

    localparam int RND_Q20 = 524288;
    localparam int RND_Q12 = 2048;
    localparam int RND_Q8  = 128;

    localparam logic [2:0] REG_PP  = 3'd0;
    localparam logic [2:0] REG_IFX = 3'd1;
    localparam logic [2:0] REG_IFY = 3'd2;
    localparam logic [2:0] REG_K1  = 3'd3;
    localparam logic [2:0] REG_K2  = 3'd4;
    localparam logic [2:0] REG_K3  = 3'd5;
    localparam logic [2:0] REG_P1  = 3'd6;
    localparam logic [2:0] REG_P2  = 3'd7;

    localparam logic signed [WIDE_W-1:0] LIM24_HI = WIDE_W'(8388607);
    localparam logic signed [WIDE_W-1:0] LIM24_LO = WIDE_W'(-8388608);
    localparam logic signed [WIDE_W-1:0] LIM32_HI = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] LIM32_LO = WIDE_W'(-64'sd2147483648);

    typedef struct packed {
        logic [15:0]        cy;
        logic [15:0]        cx;
        logic [23:0]        ifx;
        logic [23:0]        ify;
        logic signed [23:0] k1;
        logic signed [23:0] k2;
        logic signed [23:0] k3;
        logic signed [23:0] p1;
        logic signed [23:0] p2;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic                  sat;
        logic [DEPTH_BITS-1:0] depth;
    } t_tag;

    typedef struct packed {
        logic               clip;
        logic signed [23:0] val;
    } t_sat24;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat32;

    function automatic t_sat24 sat24(input logic signed [WIDE_W-1:0] v);
        t_sat24 r;
        r.clip = 1'b0;
        r.val  = v[23:0];
        if (v > LIM24_HI) begin
            r.clip = 1'b1;
            r.val  = 24'h7fffff;
        end else if (v < LIM24_LO) begin
            r.clip = 1'b1;
            r.val  = 24'h800000;
        end
        return r;
    endfunction

    function automatic t_sat32 sat32(input logic signed [WIDE_W-1:0] v);
        t_sat32 r;
        r.clip = 1'b0;
        r.val  = v[31:0];
        if (v > LIM32_HI) begin
            r.clip = 1'b1;
            r.val  = 32'h7fffffff;
        end else if (v < LIM32_LO) begin
            r.clip = 1'b1;
            r.val  = 32'h80000000;
        end
        return r;
    endfunction

endpackage

// ===== design/depth_pixel_deprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_deprojection
// Turns a depth pixel into a 3D point through a pinhole model with
// Brown-Conrady lens distortion, in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one word per clock while the output side is not stalled,
// and returns one point word per input word, in order. Eleven register stages
// carry the work: principal point offset, focal scaling, squares, radius sums,
// and at most one multiplier level per stage for the radial and tangential
// terms, ending with the depth scaling in the output register. While an output
// word waits to be taken the whole pipeline holds and input ready is low; it
// never drops or repeats a word. Configuration must be written through the
// APB-style port only while the pipeline is empty; the block does not enforce it.
module depth_pixel_deprojection
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_BITS-1:0]   i_pixel_col,
    input  logic [PIX_BITS-1:0]   i_pixel_row,
    input  logic [DEPTH_BITS-1:0] i_depth,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_point_x,
    output logic signed [31:0]    o_point_y,
    output logic [DEPTH_BITS-1:0] o_point_z,
    output logic                  o_saturated,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_AW-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg               cfg;
    logic               pipe_en;
    t_tag               norm_tag, dist_tag;
    logic signed [23:0] norm_x, norm_y;
    logic signed [31:0] dist_ux, dist_uy;

    assign pipe_en = !o_valid || i_ready;
    assign o_ready = pipe_en;

    dpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dpd_norm u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_depth     (i_depth),
        .o_tag       (norm_tag),
        .o_x         (norm_x),
        .o_y         (norm_y)
    );

    dpd_distort u_distort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_cfg   (cfg),
        .i_tag   (norm_tag),
        .i_x     (norm_x),
        .i_y     (norm_y),
        .o_tag   (dist_tag),
        .o_ux    (dist_ux),
        .o_uy    (dist_uy)
    );

    dpd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_tag       (dist_tag),
        .i_ux        (dist_ux),
        .i_uy        (dist_uy),
        .o_valid     (o_valid),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_saturated (o_saturated)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input accepted while output stalled");

endmodule

// ===== design/dpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dpd_cfg_regs
// APB-style register file holding the camera intrinsics and distortion
// coefficients.
// ----------------------------------------------------------------------------
module dpd_cfg_regs
    import dpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [2:0] reg_idx;
    logic       wr_en;
    t_cfg       r_cfg;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PP: begin
                    r_cfg.cx <= pwdata[15:0];
                    r_cfg.cy <= pwdata[31:16];
                end
                REG_IFX: r_cfg.ifx <= pwdata[23:0];
                REG_IFY: r_cfg.ify <= pwdata[23:0];
                REG_K1:  r_cfg.k1  <= pwdata[23:0];
                REG_K2:  r_cfg.k2  <= pwdata[23:0];
                REG_K3:  r_cfg.k3  <= pwdata[23:0];
                REG_P1:  r_cfg.p1  <= pwdata[23:0];
                REG_P2:  r_cfg.p2  <= pwdata[23:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PP:  prdata = {r_cfg.cy, r_cfg.cx};
            REG_IFX: prdata = {8'h00, r_cfg.ifx};
            REG_IFY: prdata = {8'h00, r_cfg.ify};
            REG_K1:  prdata = {8'h00, r_cfg.k1};
            REG_K2:  prdata = {8'h00, r_cfg.k2};
            REG_K3:  prdata = {8'h00, r_cfg.k3};
            REG_P1:  prdata = {8'h00, r_cfg.p1};
            REG_P2:  prdata = {8'h00, r_cfg.p2};
        endcase
    end

    a_pp_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_idx == REG_PP) |=> ({r_cfg.cy, r_cfg.cx} == $past(pwdata)))
        else $error("principal point write not captured");

    a_k1_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_idx == REG_K1) |=> (r_cfg.k1 == $past(pwdata[23:0])))
        else $error("k1 write not captured");

endmodule

// ===== design/dpd_norm.sv =====
// ----------------------------------------------------------------------------
// dpd_norm
// Two pipeline stages: offset by the principal point, then scale by the
// reciprocal focal lengths into saturated Q4.20 normalized coordinates.
// ----------------------------------------------------------------------------
module dpd_norm
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [PIX_BITS-1:0]   i_pixel_col,
    input  logic [PIX_BITS-1:0]   i_pixel_row,
    input  logic [DEPTH_BITS-1:0] i_depth,
    output t_tag                  o_tag,
    output logic signed [23:0]    o_x,
    output logic signed [23:0]    o_y
);

    logic signed [DX_W-1:0]    n_dx, n_dy, r_dx, r_dy;
    logic signed [DX_W+24:0]   prod_x, prod_y, rsum_x, rsum_y;
    t_sat24                    sx, sy;
    t_tag                      r_tag1, r_tag2;
    logic signed [23:0]        r_x, r_y;

    assign n_dx = DX_W'({i_pixel_col, 4'b0000}) - DX_W'(i_cfg.cx);
    assign n_dy = DX_W'({i_pixel_row, 4'b0000}) - DX_W'(i_cfg.cy);

    assign prod_x = r_dx * $signed({1'b0, i_cfg.ifx});
    assign prod_y = r_dy * $signed({1'b0, i_cfg.ify});
    assign rsum_x = prod_x + (DX_W+25)'(RND_Q8);
    assign rsum_y = prod_y + (DX_W+25)'(RND_Q8);
    assign sx     = sat24(WIDE_W'($signed(rsum_x[DX_W+24:8])));
    assign sy     = sat24(WIDE_W'($signed(rsum_y[DX_W+24:8])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
        end else if (i_en) begin
            r_tag1 <= '{valid: i_valid, sat: 1'b0, depth: i_depth};
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_tag2 <= '{valid: r_tag1.valid, sat: sx.clip | sy.clip,
                        depth: r_tag1.depth};
            r_x    <= sx.val;
            r_y    <= sy.val;
        end
    end

    assign o_tag = r_tag2;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

// ===== design/dpd_distort.sv =====
// ----------------------------------------------------------------------------
// dpd_distort
// Eight pipeline stages applying the Brown-Conrady radial and tangential
// warp to the normalized coordinates, at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module dpd_distort
    import dpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  t_tag               i_tag,
    input  logic signed [23:0] i_x,
    input  logic signed [23:0] i_y,
    output t_tag               o_tag,
    output logic signed [31:0] o_ux,
    output logic signed [31:0] o_uy
);

    // Stage 3: squares and cross product.
    logic signed [2*CO_W-1:0] s_xx, s_yy, s_xy;
    logic signed [SQ_W-1:0]   r3_xx, r3_yy, r3_xy;
    logic signed [23:0]       r3_x, r3_y;
    t_tag                     r3_tag;

    // Stage 4: radius squared and tangential sums.
    logic signed [R2_W-1:0]   n4_r2, r4_r2;
    logic signed [T_W-1:0]    n4_tx, n4_ty, r4_tx, r4_ty;
    logic signed [SQ_W-1:0]   r4_xy;
    logic signed [23:0]       r4_x, r4_y;
    t_tag                     r4_tag;

    // Stage 5: r^4, k1 term and tangential products.
    logic signed [2*R2_W-1:0]      s_r4;
    logic signed [CO_W+R2_W-1:0]   s_k1r2;
    logic signed [CO_W+SQ_W:0]     s_p1xy, s_p2xy;
    logic signed [CO_W+T_W-1:0]    s_p2tx, s_p1ty;
    logic signed [24:0]            p1x2, p2x2;
    t_sat32                        sat_r4;
    logic signed [31:0]            r5_r4;
    logic signed [R2_W-1:0]        r5_r2;
    logic signed [CO_W+R2_W-21:0]  r5_k1r2;
    logic signed [CO_W+SQ_W-20:0]  r5_p1xy, r5_p2xy;
    logic signed [CO_W+T_W-21:0]   r5_p2tx, r5_p1ty;
    logic signed [23:0]            r5_x, r5_y;
    t_tag                          r5_tag;

    // Stage 6: r^6 and k2 term.
    logic signed [32+R2_W-1:0]     s_r6;
    logic signed [CO_W+31:0]       s_k2r4;
    t_sat32                        sat_r6;
    logic signed [31:0]            r6_r6;
    logic signed [CO_W+11:0]       r6_k2r4;
    logic signed [CO_W+R2_W-21:0]  r6_k1r2;
    logic signed [CO_W+SQ_W-20:0]  r6_p1xy, r6_p2xy;
    logic signed [CO_W+T_W-21:0]   r6_p2tx, r6_p1ty;
    logic signed [23:0]            r6_x, r6_y;
    t_tag                          r6_tag;

    // Stage 7: k3 term.
    logic signed [CO_W+31:0]       s_k3r6;
    logic signed [CO_W+11:0]       r7_k3r6, r7_k2r4;
    logic signed [CO_W+R2_W-21:0]  r7_k1r2;
    logic signed [CO_W+SQ_W-20:0]  r7_p1xy, r7_p2xy;
    logic signed [CO_W+T_W-21:0]   r7_p2tx, r7_p1ty;
    logic signed [23:0]            r7_x, r7_y;
    t_tag                          r7_tag;

    // Stage 8: radial factor.
    logic signed [SUM_W-1:0]       s_f;
    t_sat32                        sat_f;
    logic signed [31:0]            r8_f;
    logic signed [CO_W+SQ_W-20:0]  r8_p1xy, r8_p2xy;
    logic signed [CO_W+T_W-21:0]   r8_p2tx, r8_p1ty;
    logic signed [23:0]            r8_x, r8_y;
    t_tag                          r8_tag;

    // Stage 9: coordinate times radial factor.
    logic signed [CO_W+31:0]       s_xf, s_yf;
    logic signed [CO_W+11:0]       r9_xf, r9_yf;
    logic signed [CO_W+SQ_W-20:0]  r9_p1xy, r9_p2xy;
    logic signed [CO_W+T_W-21:0]   r9_p2tx, r9_p1ty;
    t_tag                          r9_tag;

    // Stage 10: distorted coordinates.
    logic signed [SUM_W-1:0]       s_ux, s_uy;
    t_sat32                        sat_ux, sat_uy;
    logic signed [31:0]            r10_ux, r10_uy;
    t_tag                          r10_tag;

    assign s_xx = i_x * i_x + (2*CO_W)'(RND_Q20);
    assign s_yy = i_y * i_y + (2*CO_W)'(RND_Q20);
    assign s_xy = i_x * i_y + (2*CO_W)'(RND_Q20);

    assign n4_r2 = R2_W'(r3_xx) + R2_W'(r3_yy);
    assign n4_tx = T_W'(n4_r2) + (T_W'(r3_xx) <<< 1);
    assign n4_ty = T_W'(n4_r2) + (T_W'(r3_yy) <<< 1);

    assign p1x2   = {i_cfg.p1, 1'b0};
    assign p2x2   = {i_cfg.p2, 1'b0};
    assign s_r4   = r4_r2 * r4_r2 + (2*R2_W)'(RND_Q20);
    assign s_k1r2 = i_cfg.k1 * r4_r2 + (CO_W+R2_W)'(RND_Q20);
    assign s_p1xy = p1x2 * r4_xy + (CO_W+SQ_W+1)'(RND_Q20);
    assign s_p2xy = p2x2 * r4_xy + (CO_W+SQ_W+1)'(RND_Q20);
    assign s_p2tx = i_cfg.p2 * r4_tx + (CO_W+T_W)'(RND_Q20);
    assign s_p1ty = i_cfg.p1 * r4_ty + (CO_W+T_W)'(RND_Q20);
    assign sat_r4 = sat32(WIDE_W'($signed(s_r4[2*R2_W-1:20])));

    assign s_r6   = r5_r4 * r5_r2 + (32+R2_W)'(RND_Q20);
    assign s_k2r4 = i_cfg.k2 * r5_r4 + (CO_W+32)'(RND_Q20);
    assign sat_r6 = sat32(WIDE_W'($signed(s_r6[32+R2_W-1:20])));

    assign s_k3r6 = i_cfg.k3 * r6_r6 + (CO_W+32)'(RND_Q20);

    assign s_f   = SUM_W'(RND_Q20 * 2) + SUM_W'(r7_k1r2) + SUM_W'(r7_k2r4)
                 + SUM_W'(r7_k3r6);
    assign sat_f = sat32(WIDE_W'(s_f));

    assign s_xf = r8_x * r8_f + (CO_W+32)'(RND_Q20);
    assign s_yf = r8_y * r8_f + (CO_W+32)'(RND_Q20);

    assign s_ux   = SUM_W'(r9_xf) + SUM_W'(r9_p1xy) + SUM_W'(r9_p2tx);
    assign s_uy   = SUM_W'(r9_yf) + SUM_W'(r9_p2xy) + SUM_W'(r9_p1ty);
    assign sat_ux = sat32(WIDE_W'(s_ux));
    assign sat_uy = sat32(WIDE_W'(s_uy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag.valid  <= 1'b0;
            r4_tag.valid  <= 1'b0;
            r5_tag.valid  <= 1'b0;
            r6_tag.valid  <= 1'b0;
            r7_tag.valid  <= 1'b0;
            r8_tag.valid  <= 1'b0;
            r9_tag.valid  <= 1'b0;
            r10_tag.valid <= 1'b0;
        end else if (i_en) begin
            r3_xx  <= $signed(s_xx[2*CO_W-1:20]);
            r3_yy  <= $signed(s_yy[2*CO_W-1:20]);
            r3_xy  <= $signed(s_xy[2*CO_W-1:20]);
            r3_x   <= i_x;
            r3_y   <= i_y;
            r3_tag <= i_tag;

            r4_r2  <= n4_r2;
            r4_tx  <= n4_tx;
            r4_ty  <= n4_ty;
            r4_xy  <= r3_xy;
            r4_x   <= r3_x;
            r4_y   <= r3_y;
            r4_tag <= r3_tag;

            r5_r4   <= sat_r4.val;
            r5_r2   <= r4_r2;
            r5_k1r2 <= $signed(s_k1r2[CO_W+R2_W-1:20]);
            r5_p1xy <= $signed(s_p1xy[CO_W+SQ_W:20]);
            r5_p2xy <= $signed(s_p2xy[CO_W+SQ_W:20]);
            r5_p2tx <= $signed(s_p2tx[CO_W+T_W-1:20]);
            r5_p1ty <= $signed(s_p1ty[CO_W+T_W-1:20]);
            r5_x    <= r4_x;
            r5_y    <= r4_y;
            r5_tag  <= '{valid: r4_tag.valid, sat: r4_tag.sat | sat_r4.clip,
                         depth: r4_tag.depth};

            r6_r6   <= sat_r6.val;
            r6_k2r4 <= $signed(s_k2r4[CO_W+31:20]);
            r6_k1r2 <= r5_k1r2;
            r6_p1xy <= r5_p1xy;
            r6_p2xy <= r5_p2xy;
            r6_p2tx <= r5_p2tx;
            r6_p1ty <= r5_p1ty;
            r6_x    <= r5_x;
            r6_y    <= r5_y;
            r6_tag  <= '{valid: r5_tag.valid, sat: r5_tag.sat | sat_r6.clip,
                         depth: r5_tag.depth};

            r7_k3r6 <= $signed(s_k3r6[CO_W+31:20]);
            r7_k2r4 <= r6_k2r4;
            r7_k1r2 <= r6_k1r2;
            r7_p1xy <= r6_p1xy;
            r7_p2xy <= r6_p2xy;
            r7_p2tx <= r6_p2tx;
            r7_p1ty <= r6_p1ty;
            r7_x    <= r6_x;
            r7_y    <= r6_y;
            r7_tag  <= r6_tag;

            r8_f    <= sat_f.val;
            r8_p1xy <= r7_p1xy;
            r8_p2xy <= r7_p2xy;
            r8_p2tx <= r7_p2tx;
            r8_p1ty <= r7_p1ty;
            r8_x    <= r7_x;
            r8_y    <= r7_y;
            r8_tag  <= '{valid: r7_tag.valid, sat: r7_tag.sat | sat_f.clip,
                         depth: r7_tag.depth};

            r9_xf   <= $signed(s_xf[CO_W+31:20]);
            r9_yf   <= $signed(s_yf[CO_W+31:20]);
            r9_p1xy <= r8_p1xy;
            r9_p2xy <= r8_p2xy;
            r9_p2tx <= r8_p2tx;
            r9_p1ty <= r8_p1ty;
            r9_tag  <= r8_tag;

            r10_ux  <= sat_ux.val;
            r10_uy  <= sat_uy.val;
            r10_tag <= '{valid: r9_tag.valid,
                         sat: r9_tag.sat | sat_ux.clip | sat_uy.clip,
                         depth: r9_tag.depth};
        end
    end

    assign o_tag = r10_tag;
    assign o_ux  = r10_ux;
    assign o_uy  = r10_uy;

endmodule

// ===== design/dpd_scale.sv =====
// ----------------------------------------------------------------------------
// dpd_scale
// Final stage and output register: scales the distorted coordinates by the
// depth into saturated Q24.8 points.
// ----------------------------------------------------------------------------
module dpd_scale
    import dpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_tag                  i_tag,
    input  logic signed [31:0]    i_ux,
    input  logic signed [31:0]    i_uy,
    output logic                  o_valid,
    output logic signed [31:0]    o_point_x,
    output logic signed [31:0]    o_point_y,
    output logic [DEPTH_BITS-1:0] o_point_z,
    output logic                  o_saturated
);

    localparam int D_W = DEPTH_BITS + 1;

    logic signed [D_W-1:0]    dep;
    logic signed [D_W+31:0]   s_px, s_py;
    t_sat32                   sat_px, sat_py;
    logic                     r_valid;
    logic signed [31:0]       r_px, r_py;
    logic [DEPTH_BITS-1:0]    r_pz;
    logic                     r_sat;

    assign dep    = $signed({1'b0, i_tag.depth});
    assign s_px   = dep * i_ux + (D_W+32)'(RND_Q12);
    assign s_py   = dep * i_uy + (D_W+32)'(RND_Q12);
    assign sat_px = sat32(WIDE_W'($signed(s_px[D_W+31:12])));
    assign sat_py = sat32(WIDE_W'($signed(s_py[D_W+31:12])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_tag.valid;
            r_px    <= sat_px.val;
            r_py    <= sat_py.val;
            r_pz    <= i_tag.depth;
            r_sat   <= i_tag.sat | sat_px.clip | sat_py.clip;
        end
    end

    assign o_valid     = r_valid;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_point_z   = r_pz;
    assign o_saturated = r_sat;

endmodule

// ===== tb/depth_pixel_deprojection_test.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_deprojection_test
// Self-checking bench for the depth pixel deprojection pipeline. It sends
// pixel words through the valid/ready input, with bursts and gaps on the
// input and stalls on the output. It predicts each point word in fixed point
// from a shadow copy of the APB registers unless the directed table gives it,
// and checks the words in order. A directed table comes first. Random phases
// follow under lens, extreme and arbitrary register setups.
// ----------------------------------------------------------------------------
module depth_pixel_deprojection_test
    import dpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 225;
    localparam int LONG_HOLD    = 300;
    localparam int PLAN_LEN     = 20;
    localparam int SETUP_PHASES = 9;

    typedef enum logic [2:0] {
        CFG_RESET, CFG_NOMINAL, CFG_WIDE_OPEN, CFG_WARP_MAX,
        CFG_WARP_MIN, CFG_LENS, CFG_ANY
    } t_setup;

    typedef struct packed {
        logic signed [31:0]    x;
        logic signed [31:0]    y;
        logic [DEPTH_BITS-1:0] z;
        logic                  sat;
    } t_point;

    typedef struct packed {
        t_setup                setup;
        logic [PIX_BITS-1:0]   col;
        logic [PIX_BITS-1:0]   row;
        logic [DEPTH_BITS-1:0] depth;
        logic                  typed;
        t_point                pt;
    } t_probe;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PIX_BITS-1:0]   i_pixel_col = '0;
    logic [PIX_BITS-1:0]   i_pixel_row = '0;
    logic [DEPTH_BITS-1:0] i_depth = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [31:0]    o_point_x;
    logic signed [31:0]    o_point_y;
    logic [DEPTH_BITS-1:0] o_point_z;
    logic                  o_saturated;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_AW-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    t_cfg   shadow_cfg = '0;
    t_point expected_points [$];
    t_point want_pt;
    int     errors = 0;
    int     words_in = 0;
    int     words_out = 0;
    int     clipped_out = 0;
    int     input_stalls = 0;
    int     setups_done = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    bit     long_hold_done = 1'b0;

    t_probe plan [PLAN_LEN] = '{
        '{CFG_RESET, 12'd0, 12'd0, 16'd0, 1'b1, '{32'sd0, 32'sd0, 16'd0, 1'b0}},
        '{CFG_RESET, 12'd4095, 12'd4095, 16'd65535, 1'b1,
          '{32'sd0, 32'sd0, 16'd65535, 1'b0}},
        '{CFG_RESET, 12'd2048, 12'd1024, 16'd32768, 1'b1,
          '{32'sd0, 32'sd0, 16'd32768, 1'b0}},
        '{CFG_RESET, 12'd4095, 12'd0, 16'd1, 1'b1, '{32'sd0, 32'sd0, 16'd1, 1'b0}},
        '{CFG_NOMINAL, 12'd320, 12'd240, 16'd1000, 1'b0, '0},
        '{CFG_NOMINAL, 12'd0, 12'd0, 16'd65535, 1'b0, '0},
        '{CFG_NOMINAL, 12'd4095, 12'd4095, 16'd65535, 1'b0, '0},
        '{CFG_NOMINAL, 12'd4095, 12'd0, 16'd0, 1'b0, '0},
        '{CFG_NOMINAL, 12'd0, 12'd4095, 16'd12345, 1'b0, '0},
        '{CFG_NOMINAL, 12'd321, 12'd240, 16'd65535, 1'b0, '0},
        '{CFG_WIDE_OPEN, 12'd4095, 12'd4095, 16'd0, 1'b1,
          '{32'sd0, 32'sd0, 16'd0, 1'b1}},
        '{CFG_WIDE_OPEN, 12'd0, 12'd0, 16'd65535, 1'b1,
          '{32'sd0, 32'sd0, 16'd65535, 1'b0}},
        '{CFG_WIDE_OPEN, 12'd1, 12'd1, 16'd4096, 1'b0, '0},
        '{CFG_WIDE_OPEN, 12'd4095, 12'd4095, 16'd65535, 1'b0, '0},
        '{CFG_WARP_MAX, 12'd0, 12'd0, 16'd65535, 1'b0, '0},
        '{CFG_WARP_MAX, 12'd4095, 12'd4095, 16'd65535, 1'b0, '0},
        '{CFG_WARP_MAX, 12'd2048, 12'd2048, 16'd1, 1'b0, '0},
        '{CFG_WARP_MIN, 12'd0, 12'd0, 16'd65535, 1'b0, '0},
        '{CFG_WARP_MIN, 12'd4095, 12'd4095, 16'd65535, 1'b0, '0},
        '{CFG_WARP_MIN, 12'd100, 12'd3000, 16'd40000, 1'b0, '0}
    };

    t_setup random_order [SETUP_PHASES] = '{
        CFG_LENS, CFG_ANY, CFG_LENS, CFG_WARP_MIN, CFG_LENS,
        CFG_WIDE_OPEN, CFG_ANY, CFG_WARP_MAX, CFG_LENS
    };

    depth_pixel_deprojection dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_depth     (i_depth),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_saturated (o_saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q20(input longint a, input longint b);
        return round_down_shift(a * b, 20);
    endfunction

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic t_point deproject_pixel(input logic [PIX_BITS-1:0] col,
                                               input logic [PIX_BITS-1:0] row,
                                               input logic [DEPTH_BITS-1:0] depth,
                                               input t_cfg c);
        t_point p;
        bit     hit;
        longint k1, k2, k3, p1, p2, d, t;
        longint nx, ny, xx, yy, xy, r2, r4, r6, f, ux, uy, px, py;
        hit = 1'b0;
        k1 = longint'($signed(c.k1));
        k2 = longint'($signed(c.k2));
        k3 = longint'($signed(c.k3));
        p1 = longint'($signed(c.p1));
        p2 = longint'($signed(c.p2));
        d  = longint'(depth);

        t  = round_down_shift((longint'(col) * 16 - longint'(c.cx)) * longint'(c.ifx), 8);
        nx = clamp_signed(t, 24);
        hit |= nx != t;
        t  = round_down_shift((longint'(row) * 16 - longint'(c.cy)) * longint'(c.ify), 8);
        ny = clamp_signed(t, 24);
        hit |= ny != t;

        xx = mul_q20(nx, nx);
        yy = mul_q20(ny, ny);
        xy = mul_q20(nx, ny);
        r2 = xx + yy;
        t  = mul_q20(r2, r2);
        r4 = clamp_signed(t, 32);
        hit |= r4 != t;
        t  = mul_q20(r4, r2);
        r6 = clamp_signed(t, 32);
        hit |= r6 != t;

        t = (64'sd1 <<< 20) + mul_q20(k1, r2) + mul_q20(k2, r4) + mul_q20(k3, r6);
        f = clamp_signed(t, 32);
        hit |= f != t;

        t  = mul_q20(nx, f) + mul_q20(2 * p1, xy) + mul_q20(p2, r2 + 2 * xx);
        ux = clamp_signed(t, 32);
        hit |= ux != t;
        t  = mul_q20(ny, f) + mul_q20(2 * p2, xy) + mul_q20(p1, r2 + 2 * yy);
        uy = clamp_signed(t, 32);
        hit |= uy != t;

        t  = round_down_shift(d * ux, 12);
        px = clamp_signed(t, 32);
        hit |= px != t;
        t  = round_down_shift(d * uy, 12);
        py = clamp_signed(t, 32);
        hit |= py != t;

        p.x   = px[31:0];
        p.y   = py[31:0];
        p.z   = depth;
        p.sat = hit;
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] got;
        mask = (idx == REG_PP) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PP:  {shadow_cfg.cy, shadow_cfg.cx} = value;
            REG_IFX: shadow_cfg.ifx = value[23:0];
            REG_IFY: shadow_cfg.ify = value[23:0];
            REG_K1:  shadow_cfg.k1 = value[23:0];
            REG_K2:  shadow_cfg.k2 = value[23:0];
            REG_K3:  shadow_cfg.k3 = value[23:0];
            REG_P1:  shadow_cfg.p1 = value[23:0];
            REG_P2:  shadow_cfg.p2 = value[23:0];
            default: ;
        endcase
        if ((got & mask) != (value & mask)) begin
            $error("register %0d readback: expected %h, got %h", idx, value & mask,
                   got & mask);
            errors++;
        end
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_setup kind);
        logic [2:0]  reg_order [8] = '{REG_PP, REG_IFX, REG_IFY, REG_K1, REG_K2,
                                       REG_K3, REG_P1, REG_P2};
        logic [31:0] v [8];
        case (kind)
            CFG_NOMINAL: begin
                v = '{32'h0F00_1408, 32'd27280, 32'd27300, 32'd104858, -32'sd262144,
                      32'd52429, 32'd1049, -32'sd1024};
            end
            CFG_WIDE_OPEN: begin
                v = '{32'd0, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            end
            CFG_WARP_MAX: begin
                v = '{32'h8000_8000, 32'hFF_FFFF, 32'hFF_FFFF, 32'h7F_FFFF, 32'h7F_FFFF,
                      32'h7F_FFFF, 32'h7F_FFFF, 32'h7F_FFFF};
            end
            CFG_WARP_MIN: begin
                v = '{32'hFFFF_FFFF, 32'd27280, 32'd27300, 32'h80_0000, 32'h80_0000,
                      32'h80_0000, 32'h80_0000, 32'h80_0000};
            end
            CFG_LENS: begin
                v[0] = $urandom;
                v[1] = 32'((1 << 24) / $urandom_range(150, 3000));
                v[2] = 32'((1 << 24) / $urandom_range(150, 3000));
                for (int i = 3; i < 6; i++) begin
                    v[i] = 32'(int'($urandom_range(0, 1048576)) - 524288);
                end
                for (int i = 6; i < 8; i++) begin
                    v[i] = 32'(int'($urandom_range(0, 8192)) - 4096);
                end
            end
            CFG_ANY: begin
                foreach (v[i]) v[i] = $urandom;
            end
            default: begin
                foreach (v[i]) v[i] = '0;
            end
        endcase
        foreach (reg_order[i]) write_reg(reg_order[i], v[i]);
        setups_done++;
    endtask

    task automatic drain_points();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_word(input logic [PIX_BITS-1:0] col, input logic [PIX_BITS-1:0] row,
                             input logic [DEPTH_BITS-1:0] depth, input logic typed,
                             input t_point typed_pt);
        i_valid     <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        i_depth     <= depth;
        do @(posedge i_clk); while (!o_ready);
        expected_points.insert(expected_points.size(),
                               typed ? typed_pt : deproject_pixel(col, row, depth, shadow_cfg));
        words_in++;
    endtask

    initial begin : receiver
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            if (!long_hold_done && words_in > 700) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                repeat (span) begin
                    case (mode)
                        0:       i_ready <= 1'b1;
                        1:       i_ready <= 1'($urandom_range(0, 1));
                        2:       i_ready <= ($urandom_range(0, 3) != 0);
                        default: i_ready <= ($urandom_range(0, 7) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_ready) begin
            input_stalls++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            words_out++;
            if (o_saturated) begin
                clipped_out++;
            end
            if (expected_points.size() == 0) begin
                $error("point word arrived with nothing pending");
                errors++;
            end else begin
                want_pt = expected_points.pop_front();
                if (o_point_x !== want_pt.x) begin
                    $error("point_x: expected %0d, got %0d", want_pt.x, o_point_x);
                    errors++;
                end
                if (o_point_y !== want_pt.y) begin
                    $error("point_y: expected %0d, got %0d", want_pt.y, o_point_y);
                    errors++;
                end
                if (o_point_z !== want_pt.z) begin
                    $error("point_z: expected %0d, got %0d", want_pt.z, o_point_z);
                    errors++;
                end
                if (o_saturated !== want_pt.sat) begin
                    $error("saturated: expected %0d, got %0d", want_pt.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("depth_pixel_deprojection_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_setup                current;
        logic [PIX_BITS-1:0]   col;
        logic [PIX_BITS-1:0]   row;
        logic [DEPTH_BITS-1:0] depth;
        current = CFG_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].setup != current) begin
                drain_points();
                apply_setup(plan[i].setup);
                current = plan[i].setup;
            end
            pace_sender();
            send_word(plan[i].col, plan[i].row, plan[i].depth, plan[i].typed, plan[i].pt);
        end

        foreach (random_order[p]) begin
            drain_points();
            apply_setup(random_order[p]);
            repeat (PHASE_WORDS) begin
                col = PIX_BITS'($urandom);
                row = PIX_BITS'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    col = shadow_cfg.cx[15:4] + PIX_BITS'($urandom_range(0, 63)) - 12'd32;
                    row = shadow_cfg.cy[15:4] + PIX_BITS'($urandom_range(0, 63)) - 12'd32;
                end
                case ($urandom_range(0, 3))
                    0, 1:    depth = DEPTH_BITS'($urandom);
                    2:       depth = DEPTH_BITS'($urandom_range(0, 4095));
                    default: depth = $urandom_range(0, 1) ? '1 : '0;
                endcase
                pace_sender();
                send_word(col, row, depth, 1'b0, '0);
            end
        end

        drain_points();
        repeat (30) @(posedge i_clk);
        $display("Checked %0d of %0d point words over %0d register setups, %0d clipped.",
                 words_out, words_in, setups_done, clipped_out);
        $display("Input side was stalled for %0d cycles, including one %0d-cycle hold.",
                 input_stalls, LONG_HOLD);
        if (errors == 0) begin
            $display("depth_pixel_deprojection_test: PASS");
        end else begin
            $display("depth_pixel_deprojection_test: FAIL");
        end
        $finish;
    end

endmodule
